// ----- rtl/core/blr_pkg.sv -----
// Shared types, request codes and helper functions for the LSB-first bit reader.
// No dependencies; every module of the reader imports this package.
`default_nettype none

package blr_pkg;

  // Default store depth in 32-bit words.
  localparam int STORE_WORDS_DEF = 256;

  // Stream widths: input payload padded to whole bytes, output is one word.
  localparam int S_TDATA_W = 72;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 32;

  // Request kinds carried on s_tuser.
  typedef enum logic [2:0] {
    REQ_LOAD  = 3'd0,
    REQ_START = 3'd1,
    REQ_READ  = 3'd2,
    REQ_PEEK  = 3'd3,
    REQ_SKIP  = 3'd4
  } req_t;

  // Read width codes.
  typedef enum logic [1:0] {
    WID_1  = 2'd0,
    WID_8  = 2'd1,
    WID_16 = 2'd2,
    WID_32 = 2'd3
  } wid_t;

  // Position update controls, top level to position unit.
  typedef struct packed {
    logic start;
    logic advance;
  } pos_ctl_t;

  // Word store port enables, top level to store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

  // Bit count of a width code.
  function automatic logic [5:0] wid_bits(input wid_t w);
    logic [5:0] n;
    unique case (w)
      WID_1:   n = 6'd1;
      WID_8:   n = 6'd8;
      WID_16:  n = 6'd16;
      WID_32:  n = 6'd32;
      default: n = 6'd32;
    endcase
    return n;
  endfunction

  // Keep mask of a width code.
  function automatic logic [31:0] wid_mask(input wid_t w);
    logic [31:0] m;
    unique case (w)
      WID_1:   m = 32'h0000_0001;
      WID_8:   m = 32'h0000_00FF;
      WID_16:  m = 32'h0000_FFFF;
      WID_32:  m = 32'hFFFF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Remainder by shift and subtract; used on constants only, to build tables.
  function automatic int unsigned blr_mod(input int unsigned x, input int unsigned n);
    int unsigned r;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      r = (r << 1) | ((x >> i) & 32'd1);
      if (r >= n) begin
        r = r - n;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/blr_pos.sv -----
// Read position unit of the bit reader: word pointer and bit offset registers.
// Depends on blr_pkg (control struct, remainder helper for the wrap tables).
`default_nettype none

module blr_pos
  import blr_pkg::*;
#(
  parameter int  STORE_WORDS = STORE_WORDS_DEF,
  localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pos_ctl_t      ctl,
  input  wire logic [9:0]    start_byte,
  input  wire logic [7:0]    word_index,
  input  wire logic [15:0]   count,
  output logic      [AW-1:0] word_ptr,
  output logic      [AW-1:0] word_ptr_inc,
  output logic      [4:0]    bit_ptr,
  output logic      [AW-1:0] load_addr
);

  localparam logic [AW+1:0] N_EXT = (AW + 2)'(STORE_WORDS);
  localparam logic [AW-1:0] LAST  = AW'(STORE_WORDS - 1);

  // Constant wrap tables: low byte mod N, and high nibble times 256 mod N.
  logic [AW-1:0] mod8_tab [256];
  logic [AW-1:0] hi_tab   [16];

  logic [16:0]   bit_sum;
  logic [11:0]   carry;
  logic [AW+1:0] wsum;
  logic [AW+1:0] wsum1;
  logic [AW+1:0] wsum2;
  logic [AW-1:0] word_ptr_next;
  logic [4:0]    bit_ptr_next;

  for (genvar g = 0; g < 256; g++) begin : g_mod8
    assign mod8_tab[g] = AW'(blr_mod(g, STORE_WORDS));
  end

  for (genvar h = 0; h < 16; h++) begin : g_hi
    assign hi_tab[h] = AW'(blr_mod(h * 256, STORE_WORDS));
  end

  // Words carried out of the bit offset, folded back into the store range.
  assign bit_sum = {12'd0, bit_ptr} + {1'b0, count};
  assign carry   = bit_sum[16:5];
  assign wsum    = {2'b00, word_ptr} + {2'b00, hi_tab[carry[11:8]]}
                 + {2'b00, mod8_tab[carry[7:0]]};
  assign wsum1   = (wsum >= N_EXT) ? wsum - N_EXT : wsum;
  assign wsum2   = (wsum1 >= N_EXT) ? wsum1 - N_EXT : wsum1;

  assign word_ptr_inc = (word_ptr == LAST) ? '0 : word_ptr + 1'b1;
  assign load_addr    = mod8_tab[word_index];

  always_comb begin
    word_ptr_next = word_ptr;
    bit_ptr_next  = bit_ptr;
    if (ctl.start) begin
      word_ptr_next = mod8_tab[start_byte[9:2]];
      bit_ptr_next  = {start_byte[1:0], 3'b000};
    end else if (ctl.advance) begin
      word_ptr_next = wsum2[AW-1:0];
      bit_ptr_next  = bit_sum[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_ptr <= '0;
      bit_ptr  <= '0;
    end else begin
      word_ptr <= word_ptr_next;
      bit_ptr  <= bit_ptr_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/blr_store.sv -----
// Word store of the bit reader: one write port, two registered read ports.
// Depends on blr_pkg (store control struct).
`default_nettype none

module blr_store
  import blr_pkg::*;
#(
  parameter int  STORE_WORDS = STORE_WORDS_DEF,
  localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
  input  wire logic          clk,
  input  wire store_ctl_t    ctl,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  input  wire logic [AW-1:0] rd_addr0,
  input  wire logic [AW-1:0] rd_addr1,
  output logic      [31:0]   rd_data0,
  output logic      [31:0]   rd_data1
);

  logic [31:0] mem [STORE_WORDS];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data while the next stage is stalled.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lsb_first_bit_reader_core.sv -----
// Top level of the LSB-first bit reader over a store of 32-bit words.
// Depends on blr_pkg, blr_pos and blr_store.
//
//   Channel | Direction | Signals                     | Carries
//   --------+-----------+-----------------------------+-------------------------------
//   s       | in        | s_tvalid s_tready s_tdata   | one request: kind on s_tuser,
//           |           | s_tuser                     | operands on s_tdata
//   m       | out       | m_tvalid m_tready m_tdata   | read_data for read and peek
//
// One request per cycle while s_tready is high. A read or peek returns its word through the
// store read register, then the output register. Load, start and skip give no result and
// finish in the cycle they are taken.
// Reset (rst, synchronous) clears the read position to word 0, bit 0 and empties the
// pipeline; store contents are not cleared.
// A stall on m holds the output register; s_tready drops only when both the store
// read stage and the output register are full.
`default_nettype none

module lsb_first_bit_reader_core
  import blr_pkg::*;
#(
  parameter int  STORE_WORDS = STORE_WORDS_DEF,
  localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [7:0] word_index, [39:8] word_value, [49:40] start_byte, [51:50] width_code,
  // [67:52] skip_bits, [71:68] zero
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // [2:0] req_type
  input  wire logic [S_TUSER_W-1:0] s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [31:0] read_data
  output logic      [M_TDATA_W-1:0] m_tdata
);

  // Request fields.
  req_t        req_type;
  logic [7:0]  word_index;
  logic [31:0] word_value;
  logic [9:0]  start_byte;
  wid_t        width_code;
  logic [15:0] skip_bits;

  assign req_type   = req_t'(s_tuser);
  assign word_index = s_tdata[7:0];
  assign word_value = s_tdata[39:8];
  assign start_byte = s_tdata[49:40];
  assign width_code = wid_t'(s_tdata[51:50]);
  assign skip_bits  = s_tdata[67:52];

  // Handshake and pipeline control.
  logic       accept;
  logic       out_free;
  logic       s1_ready;
  logic       s1_valid;
  logic [4:0] s1_bit;
  wid_t       s1_wid;
  logic       s1_peek;
  logic       out_valid;
  logic [31:0] out_data;

  pos_ctl_t    pos_ctl;
  store_ctl_t  store_ctl;
  logic [15:0] count;

  logic [AW-1:0] word_ptr;
  logic [AW-1:0] word_ptr_inc;
  logic [4:0]    bit_ptr;
  logic [AW-1:0] load_addr;
  logic [31:0]   rd_data0;
  logic [31:0]   rd_data1;

  logic [63:0] pair_shifted;
  logic [31:0] result;

  assign out_free = !out_valid || m_tready;
  assign s1_ready = !s1_valid || out_free;
  assign s_tready = s1_ready;
  assign accept   = s_tvalid && s_tready;

  // Decode the request kind; unused kinds do nothing.
  always_comb begin
    pos_ctl   = '0;
    store_ctl = '0;
    count     = skip_bits;
    if (accept) begin
      unique case (req_type)
        REQ_LOAD:  store_ctl.wr_en = 1'b1;
        REQ_START: pos_ctl.start   = 1'b1;
        REQ_READ: begin
          store_ctl.rd_en = 1'b1;
          pos_ctl.advance = 1'b1;
          count           = {10'd0, wid_bits(width_code)};
        end
        REQ_PEEK:  store_ctl.rd_en = 1'b1;
        REQ_SKIP:  pos_ctl.advance = 1'b1;
        default:   ;
      endcase
    end
  end

  blr_pos #(
    .STORE_WORDS (STORE_WORDS)
  ) u_pos (
    .clk          (clk),
    .rst          (rst),
    .ctl          (pos_ctl),
    .start_byte   (start_byte),
    .word_index   (word_index),
    .count        (count),
    .word_ptr     (word_ptr),
    .word_ptr_inc (word_ptr_inc),
    .bit_ptr      (bit_ptr),
    .load_addr    (load_addr)
  );

  // Read the current word and the one after it in the cycle the request is taken;
  // the pointer registers already reflect every earlier request.
  blr_store #(
    .STORE_WORDS (STORE_WORDS)
  ) u_store (
    .clk      (clk),
    .ctl      (store_ctl),
    .wr_addr  (load_addr),
    .wr_data  (word_value),
    .rd_addr0 (word_ptr),
    .rd_addr1 (word_ptr_inc),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  // Stage 1: word pair is in the store read registers; hold the bit offset and width.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= store_ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (store_ctl.rd_en) begin
      s1_bit  <= bit_ptr;
      s1_wid  <= width_code;
      s1_peek <= (req_type == REQ_PEEK);
    end
  end

  // Extract: first stream bit lands in bit 0; reads are masked to the read width, peeks keep all 32 bits.
  assign pair_shifted = {rd_data1, rd_data0} >> s1_bit;
  assign result       = s1_peek ? pair_shifted[31:0]
                                : (pair_shifted[31:0] & wid_mask(s1_wid));

  // Output register: advance when empty or taken downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for lsb_first_bit_reader_core: streams load, start, read,
// peek and skip requests and checks every returned word against an in-bench predictor.
// Depends on blr_pkg and the reader RTL.
`timescale 1ns / 1ps

module tb;
  import blr_pkg::*;

  localparam int          STREAM_BITS   = STORE_WORDS_DEF * 32;
  localparam logic [2:0]  LAST_REQ_CODE = 3'd7;
  localparam int          TOTAL_ITEMS   = 1750;
  localparam int          IDLE_PCT      = 31;
  localparam int          CALM_FROM     = 800;
  localparam int          CALM_TO       = 1100;
  localparam int          HOLD_AT       = 400;
  localparam int          HOLD_CYCLES   = 150;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          TIMEOUT_NS    = 4_000_000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  word_index;
    logic [31:0] word_value;
    logic [9:0]  start_byte;
    logic [1:0]  width_code;
    logic [15:0] skip_bits;
  } reader_req_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  // Requests waiting to be offered, and read words still owed by the block.
  reader_req_t request_backlog[$];
  logic [31:0] expected_reads[$];

  // Planning shadow: keeps reads and peeks away from words never loaded.
  bit          plan_written[STORE_WORDS_DEF];
  int unsigned plan_pos;

  // Predictor state: store copy and flat bit position (word * 32 + bit).
  logic [31:0] stream_words[STORE_WORDS_DEF];
  int unsigned stream_pos;

  int          taken_count;
  int          failures;
  bit          offer_open;
  int          hold_left;
  bit          hold_done;
  logic [31:0] want;
  logic        calm;

  assign calm = (taken_count >= CALM_FROM) && (taken_count < CALM_TO);

  lsb_first_bit_reader_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  function automatic int unsigned span_of(input logic [1:0] code);
    case (code)
      WID_1:   return 1;
      WID_8:   return 8;
      WID_16:  return 16;
      default: return 32;
    endcase
  endfunction

  // Position after a request; a byte address times 8 is already word * 32 + byte lane * 8.
  function automatic int unsigned moved_pos(input int unsigned pos, input reader_req_t r);
    case (r.kind)
      REQ_START: return int'(r.start_byte) * 8;
      REQ_READ:  return (pos + span_of(r.width_code)) % STREAM_BITS;
      REQ_SKIP:  return (pos + int'(r.skip_bits)) % STREAM_BITS;
      default:   return pos;
    endcase
  endfunction

  // Update the predictor with one taken request and queue the word it returns, if any.
  function automatic void apply_request(input reader_req_t r);
    int unsigned cur;
    logic [63:0] pair;
    logic [63:0] keep;
    cur  = stream_pos / 32;
    pair = {stream_words[(cur + 1) % STORE_WORDS_DEF], stream_words[cur]} >> (stream_pos % 32);
    case (r.kind)
      REQ_LOAD: stream_words[r.word_index] = r.word_value;
      REQ_READ: begin
        keep = (64'd1 << span_of(r.width_code)) - 64'd1;
        expected_reads.push_back(pair[31:0] & keep[31:0]);
      end
      REQ_PEEK: expected_reads.push_back(pair[31:0]);
      default: ;
    endcase
    stream_pos = moved_pos(stream_pos, r);
  endfunction

  // Every field random, so unused operand bits toggle too.
  function automatic reader_req_t random_req();
    reader_req_t r;
    r.kind       = 3'($urandom_range(REQ_SKIP, REQ_LOAD));
    r.word_index = 8'($urandom);
    r.word_value = $urandom;
    r.start_byte = 10'($urandom);
    r.width_code = 2'($urandom);
    r.skip_bits  = 16'($urandom);
    return r;
  endfunction

  function automatic void plan(input reader_req_t r);
    if (r.kind == REQ_LOAD) begin
      plan_written[r.word_index] = 1'b1;
    end
    plan_pos = moved_pos(plan_pos, r);
    request_backlog.push_back(r);
  endfunction

  function automatic void plan_load(input logic [7:0] idx, input logic [31:0] value);
    reader_req_t r;
    r            = random_req();
    r.kind       = REQ_LOAD;
    r.word_index = idx;
    r.word_value = value;
    plan(r);
  endfunction

  // Read or peek; load the current and following word first if either is still blank.
  function automatic void plan_fetch(input logic [2:0] kind, input logic [1:0] code);
    reader_req_t r;
    int unsigned cur;
    int unsigned nxt;
    cur = plan_pos / 32;
    nxt = (cur + 1) % STORE_WORDS_DEF;
    if (!plan_written[cur]) begin
      plan_load(cur[7:0], $urandom);
    end
    if (!plan_written[nxt]) begin
      plan_load(nxt[7:0], $urandom);
    end
    r            = random_req();
    r.kind       = kind;
    r.width_code = code;
    plan(r);
  endfunction

  function automatic void plan_start(input logic [9:0] byte_addr);
    reader_req_t r;
    r            = random_req();
    r.kind       = REQ_START;
    r.start_byte = byte_addr;
    plan(r);
  endfunction

  function automatic void plan_skip(input logic [15:0] count);
    reader_req_t r;
    r           = random_req();
    r.kind      = REQ_SKIP;
    r.skip_bits = count;
    plan(r);
  endfunction

  function automatic void plan_unused(input logic [2:0] code);
    reader_req_t r;
    r      = random_req();
    r.kind = code;
    plan(r);
  endfunction

  function automatic logic [2:0] random_fetch_kind();
    return ($urandom_range(3) == 0) ? REQ_PEEK : REQ_READ;
  endfunction

  // Sender: offer the front request at the falling edge, hold it until taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!offer_open) begin
      if (request_backlog.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        s_tvalid   <= 1'b1;
        s_tuser    <= request_backlog[0].kind;
        s_tdata    <= {4'b0, request_backlog[0].skip_bits, request_backlog[0].width_code,
                       request_backlog[0].start_byte, request_backlog[0].word_value,
                       request_backlog[0].word_index};
        offer_open = 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      apply_request(request_backlog.pop_front());
      taken_count++;
      offer_open = 1'b0;
    end
  end

  // Receiver: random stalls, one long hold-off so the pipeline fills and s_tready drops.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (!hold_done && taken_count >= HOLD_AT) begin
      m_tready  <= 1'b0;
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reads.size() == 0) begin
        $error("read_data: no result expected, got %h", m_tdata);
        failures++;
      end else begin
        want = expected_reads.pop_front();
        if (m_tdata !== want) begin
          $error("read_data mismatch: expected %h, got %h", want, m_tdata);
          failures++;
        end
      end
    end
  end

  initial begin
    int roll;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    m_tready    = 1'b0;
    offer_open  = 1'b0;
    hold_left   = 0;
    hold_done   = 1'b0;
    taken_count = 0;
    failures    = 0;
    plan_pos    = 0;
    stream_pos  = 0;

    // Directed: index and data extremes, every width, wrap at the end of the store,
    // full-length skip, zero skip and the ignored request codes.
    plan_load(8'h00, 32'hC3A5_5A3D);
    plan_load(8'h01, 32'hFFFF_FFFF);
    plan_load(8'hFF, 32'h8000_0001);
    plan_load(8'hFE, 32'h0000_0000);
    plan_fetch(REQ_PEEK, WID_32);
    plan_fetch(REQ_READ, WID_1);
    plan_fetch(REQ_READ, WID_8);
    plan_fetch(REQ_READ, WID_16);
    plan_fetch(REQ_READ, WID_32);
    plan_start(10'h3FF);
    plan_fetch(REQ_PEEK, WID_32);
    plan_fetch(REQ_READ, WID_16);
    plan_start(10'h3FC);
    plan_fetch(REQ_READ, WID_32);
    plan_skip(16'hFFFF);
    plan_fetch(REQ_READ, WID_1);
    plan_skip(16'h0000);
    plan_fetch(REQ_PEEK, WID_8);
    plan_start(10'h000);
    plan_fetch(REQ_READ, WID_8);
    for (int code = REQ_SKIP + 1; code <= LAST_REQ_CODE; code++) begin
      plan_unused(code[2:0]);
    end

    // Random: mostly start-then-read runs and plain reads over loaded words.
    while (request_backlog.size() < TOTAL_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 18) begin
        plan_load(8'($urandom), $urandom);
      end else if (roll < 30) begin
        plan_start(10'($urandom_range(1023)));
        repeat ($urandom_range(8, 2)) begin
          plan_fetch(random_fetch_kind(), 2'($urandom_range(3)));
        end
      end else if (roll < 85) begin
        plan_fetch(random_fetch_kind(), 2'($urandom_range(3)));
      end else if (roll < 97) begin
        plan_skip(16'($urandom_range(1) ? $urandom_range(63) : $urandom_range(65535)));
      end else begin
        plan_unused(3'($urandom_range(LAST_REQ_CODE, REQ_SKIP + 1)));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0) @(posedge clk);
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/blr_pkg.sv
rtl/core/blr_pos.sv
rtl/core/blr_store.sv
rtl/core/lsb_first_bit_reader_core.sv
sim/tb.sv
